FILE: hw/rtl/sprite_quad_vertex_setup_defines.svh
// Assertion macros for the sprite quad vertex setup block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef SPRITE_QUAD_VERTEX_SETUP_DEFINES_SVH
`define SPRITE_QUAD_VERTEX_SETUP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SVS_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("svs check failed");
`define SVS_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("svs check failed");
`else
`define SVS_ASSERT_IMP(label, ck, rn, ante, cons)
`define SVS_ASSERT_NXT(label, ck, rn, ante, cons)
`endif
`endif

FILE: hw/rtl/svs_pkg.sv
// Shared types, constants and helpers for the sprite quad vertex setup block.
// No dependencies; imported by every module of the block.
package svs_pkg;

    localparam int SINE_TABLE_ENTRIES = 1024;
    localparam int SINE_ADDR_W        = $clog2(SINE_TABLE_ENTRIES);

    localparam logic [14:0] SIN_A   = 15'd25736;
    localparam logic [13:0] SIN_B   = 14'd10512;
    localparam logic [10:0] SIN_C   = 11'd1160;
    localparam logic [15:0] ONE_Q14 = 16'd16384;

    localparam int DIV_STEPS   = 16;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] REG_VIEWPORT_W = 3'd0;
    localparam logic [2:0] REG_VIEWPORT_H = 3'd1;
    localparam logic [2:0] REG_TEXTURE_W  = 3'd2;
    localparam logic [2:0] REG_TEXTURE_H  = 3'd3;
    localparam logic [2:0] REG_VISIBLE    = 3'd4;

    localparam logic [12:0] RST_VIEWPORT_W = 13'd1280;
    localparam logic [12:0] RST_VIEWPORT_H = 13'd720;
    localparam logic [12:0] RST_TEXTURE_W  = 13'd256;
    localparam logic [12:0] RST_TEXTURE_H  = 13'd256;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] size_x;
        logic signed [15:0] size_y;
        logic [15:0]        angle_bam;
        logic [15:0]        src_x;
        logic [15:0]        src_y;
        logic [15:0]        src_w;
        logic [15:0]        src_h;
        logic [31:0]        tint_rgba;
    } svs_in_t;

    typedef struct packed {
        logic [1:0]         corner_index;
        logic signed [15:0] ndc_x;
        logic signed [15:0] ndc_y;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic [31:0]        vertex_rgba;
        logic               last_corner;
    } svs_out_t;

    // one sprite as handed from front to back
    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [17:0] cx2;
        logic signed [17:0] cy2;
        logic signed [15:0] sn;
        logic signed [15:0] cs;
        logic [16:0]        tx0;
        logic [16:0]        tx1;
        logic [16:0]        ty0;
        logic [16:0]        ty1;
        logic [31:0]        rgba;
    } svs_job_t;

    typedef struct packed {
        logic [16:0] dw;
        logic [16:0] dh;
        logic [12:0] tw;
        logic [12:0] th;
    } svs_cfg_t;

    typedef struct packed {
        logic               done;
        logic               ovf;
        logic               neg;
        logic signed [17:0] quo;
    } svs_div_res_t;

    function automatic logic [15:0] sat_s16(input logic signed [18:0] v);
        logic [15:0] r;
        if (v > 19'sd32767)
            r = 16'h7fff;
        else if (v < -19'sd32768)
            r = 16'h8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

FILE: hw/rtl/svs_sine_rom.sv
// Sine table memory with a fill pass after reset and two registered read ports.
// Depends on svs_pkg for table size and polynomial constants.
module svs_sine_rom (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rd_en,
    input  logic [svs_pkg::SINE_ADDR_W-1:0] addr_a,
    input  logic [svs_pkg::SINE_ADDR_W-1:0] addr_b,
    output logic signed [15:0]              data_a,
    output logic signed [15:0]              data_b,
    output logic                            busy
);
    import svs_pkg::*;

    localparam int AW = SINE_ADDR_W;

    logic [15:0] mem [SINE_TABLE_ENTRIES];

    logic [AW:0]   issue_cnt_reg, issue_cnt_next;
    logic          fill_done_reg, fill_done_next;
    logic          issuing;
    logic [15:0]   phase;
    logic [14:0]   z0;

    logic          a_v_reg, b_v_reg, c_v_reg, d_v_reg;
    logic [AW-1:0] a_idx_reg, b_idx_reg, c_idx_reg, d_idx_reg;
    logic [1:0]    a_q_reg, b_q_reg, c_q_reg, d_q_reg;
    logic [14:0]   a_z_reg, b_z_reg, c_z_reg, d_z_reg;
    logic [14:0]   b_z2_reg, c_z2_reg;
    logic [13:0]   c_t1_reg;
    logic [14:0]   d_t2_reg;

    logic [29:0]   zz;
    logic [25:0]   cz;
    logic [28:0]   tz;
    logic [29:0]   tw;
    logic [15:0]   t3, s, wdata;

    assign issuing = !issue_cnt_reg[AW];
    assign phase   = 16'(issue_cnt_reg[AW-1:0]) << (16 - AW);
    // odd quadrants mirror the phase
    assign z0      = phase[14] ? (15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};

    assign zz = 30'(a_z_reg) * 30'(a_z_reg);
    assign cz = 26'(SIN_C) * 26'(b_z2_reg);
    assign tz = 29'(c_t1_reg) * 29'(c_z2_reg);
    assign tw = 30'(d_t2_reg) * 30'(d_z_reg);
    assign t3 = tw[29:14];
    assign s  = (t3 > ONE_Q14) ? ONE_Q14 : t3;
    assign wdata = d_q_reg[1] ? (16'd0 - s) : s;

    assign issue_cnt_next = issuing ? issue_cnt_reg + 1'b1 : issue_cnt_reg;
    assign fill_done_next = fill_done_reg
                          | (d_v_reg && d_idx_reg == AW'(SINE_TABLE_ENTRIES - 1));
    assign busy = !fill_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_cnt_reg <= '0;
            fill_done_reg <= 1'b0;
            a_v_reg       <= 1'b0;
            b_v_reg       <= 1'b0;
            c_v_reg       <= 1'b0;
            d_v_reg       <= 1'b0;
        end
        else
        begin
            issue_cnt_reg <= issue_cnt_next;
            fill_done_reg <= fill_done_next;
            a_v_reg       <= issuing;
            b_v_reg       <= a_v_reg;
            c_v_reg       <= b_v_reg;
            d_v_reg       <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_idx_reg <= issue_cnt_reg[AW-1:0];
        a_q_reg   <= phase[15:14];
        a_z_reg   <= z0;
        b_idx_reg <= a_idx_reg;
        b_q_reg   <= a_q_reg;
        b_z_reg   <= a_z_reg;
        b_z2_reg  <= zz[28:14];
        c_idx_reg <= b_idx_reg;
        c_q_reg   <= b_q_reg;
        c_z_reg   <= b_z_reg;
        c_z2_reg  <= b_z2_reg;
        c_t1_reg  <= SIN_B - cz[25:14];
        d_idx_reg <= c_idx_reg;
        d_q_reg   <= c_q_reg;
        d_z_reg   <= c_z_reg;
        d_t2_reg  <= SIN_A - tz[28:14];
    end

    always_ff @(posedge clk)
    begin
        if (d_v_reg)
            mem[d_idx_reg] <= wdata;
        if (rd_en)
        begin
            data_a <= mem[addr_a];
            data_b <= mem[addr_b];
        end
    end

endmodule

FILE: hw/rtl/svs_front.sv
// Request intake: visibility filter, sine/cosine lookup and the job queue.
// Depends on svs_pkg; drives the svs_sine_rom read ports and feeds svs_back through the queue.
`include "sprite_quad_vertex_setup_defines.svh"
module svs_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  svs_pkg::svs_in_t                req,
    input  logic                            visible,
    output logic                            rom_rd_en,
    output logic [svs_pkg::SINE_ADDR_W-1:0] rom_addr_a,
    output logic [svs_pkg::SINE_ADDR_W-1:0] rom_addr_b,
    input  logic signed [15:0]              rom_data_a,
    input  logic signed [15:0]              rom_data_b,
    input  logic                            rom_busy,
    output logic                            q_valid,
    output svs_pkg::svs_job_t               q_head,
    input  logic                            q_pop
);
    import svs_pkg::*;

    svs_job_t             q_mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] q_count_reg, q_count_next;
    logic                 q_full;

    logic                 f_valid_reg, f_valid_next;
    svs_in_t              f_item_reg;
    logic                 accept, push;
    logic [15:0]          cos_angle;
    svs_job_t             job;

    assign q_full    = (q_count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign q_valid   = (q_count_reg != '0);
    assign q_head    = q_mem_reg[rd_ptr_reg];

    assign req_stall = rom_busy | (f_valid_reg & q_full);
    assign accept    = req_valid & !req_stall;
    assign push      = f_valid_reg & !q_full;

    assign cos_angle  = req.angle_bam + 16'h4000;
    assign rom_rd_en  = accept & visible;
    assign rom_addr_a = req.angle_bam[15 -: SINE_ADDR_W];
    assign rom_addr_b = cos_angle[15 -: SINE_ADDR_W];

    always_comb
    begin
        job.sx   = f_item_reg.size_x;
        job.sy   = f_item_reg.size_y;
        job.cx2  = {f_item_reg.pos_x[15], f_item_reg.pos_x, 1'b0}
                 + {{2{f_item_reg.size_x[15]}}, f_item_reg.size_x};
        job.cy2  = {f_item_reg.pos_y[15], f_item_reg.pos_y, 1'b0}
                 + {{2{f_item_reg.size_y[15]}}, f_item_reg.size_y};
        job.sn   = rom_data_a;
        job.cs   = rom_data_b;
        job.tx0  = {1'b0, f_item_reg.src_x};
        job.tx1  = {1'b0, f_item_reg.src_x} + {1'b0, f_item_reg.src_w};
        job.ty0  = {1'b0, f_item_reg.src_y};
        job.ty1  = {1'b0, f_item_reg.src_y} + {1'b0, f_item_reg.src_h};
        job.rgba = f_item_reg.tint_rgba;
    end

    assign f_valid_next = rom_rd_en | (f_valid_reg & !push);
    assign wr_ptr_next  = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next  = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    assign q_count_next = q_count_reg + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(q_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            q_count_reg <= q_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rom_rd_en)
            f_item_reg <= req;
        if (push)
            q_mem_reg[wr_ptr_reg] <= job;
    end

    `SVS_ASSERT_IMP(a_no_accept_in_fill, clk, rst_n, accept, !rom_busy)
    `SVS_ASSERT_IMP(a_queue_bound, clk, rst_n, 1'b1, q_count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
    `SVS_ASSERT_NXT(a_queue_grow, clk, rst_n, push && !q_pop, q_count_reg == $past(q_count_reg) + 1'b1)

endmodule

FILE: hw/rtl/svs_divider.sv
// Restoring divider, one quotient bit per cycle, floor rounding, overflow flag.
// Depends on svs_pkg; quotient magnitude below 2^16 unless ovf is set.
module svs_divider (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [35:0]       num,
    input  logic [16:0]              den,
    output svs_pkg::svs_div_res_t    res
);
    import svs_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [35:0]          rem_reg, ds_reg;
    logic [15:0]          qa_reg;
    logic                 neg_reg, ovf_reg;
    logic [35:0]          mag;
    logic                 ge;
    logic signed [17:0]   qpos;

    assign mag = num[35] ? (36'd0 - num) : num;
    assign ge  = (rem_reg >= ds_reg);

    assign busy_next = start | (busy_reg & (cnt_reg != DIV_CNT_W'(DIV_STEPS - 1)));
    assign done_next = !start & (done_reg | (busy_reg & (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= mag;
            ds_reg  <= {4'b0, den, 15'b0};
            qa_reg  <= '0;
            cnt_reg <= '0;
            neg_reg <= num[35];
            ovf_reg <= (mag >= {3'b0, den, 16'b0});
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_reg - ds_reg : rem_reg;
            qa_reg  <= {qa_reg[14:0], ge};
            ds_reg  <= ds_reg >> 1;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // negative dividend: floor = -(q + (rem != 0))
    assign qpos     = {2'b0, qa_reg} + 18'(rem_reg != '0);
    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.neg  = neg_reg;
    assign res.quo  = neg_reg ? (18'sd0 - qpos) : $signed({2'b0, qa_reg});

endmodule

FILE: hw/rtl/svs_back.sv
// Per-corner sequencer: rotation products, four dividers, saturation, output register.
// Depends on svs_pkg and svs_divider; takes jobs from the svs_front queue.
`include "sprite_quad_vertex_setup_defines.svh"
module svs_back (
    input  logic                clk,
    input  logic                rst_n,
    input  svs_pkg::svs_cfg_t   cfg,
    input  logic                q_valid,
    input  svs_pkg::svs_job_t   q_head,
    output logic                q_pop,
    output logic                vtx_valid,
    input  logic                vtx_stall,
    output svs_pkg::svs_out_t   vtx
);
    import svs_pkg::*;

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_MUL   = 3'd1;
    localparam logic [2:0] B_START = 3'd2;
    localparam logic [2:0] B_DIV   = 3'd3;
    localparam logic [2:0] B_OUT   = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         corner_reg, corner_next;
    svs_job_t           job_reg;
    logic               out_valid_reg, out_valid_next;
    svs_out_t           out_reg;
    logic               out_load, div_start, all_done;

    logic signed [16:0] dx, dy;
    logic signed [32:0] p_cdx_reg, p_sdy_reg, p_sdx_reg, p_cdy_reg;
    logic signed [35:0] num_x, num_y, num_u, num_v;
    logic [16:0]        tsel_u, tsel_v;
    svs_div_res_t       rx, ry, ru, rv;
    svs_out_t           vert;

    assign dx = corner_reg[0] ? {job_reg.sx[15], job_reg.sx} : -{job_reg.sx[15], job_reg.sx};
    assign dy = corner_reg[1] ? {job_reg.sy[15], job_reg.sy} : -{job_reg.sy[15], job_reg.sy};

    assign tsel_u = corner_reg[0] ? job_reg.tx1 : job_reg.tx0;
    assign tsel_v = corner_reg[1] ? job_reg.ty1 : job_reg.ty0;

    // centre is Q.5, so Q.19 after the Q1.14 scale
    assign num_x = (36'(job_reg.cx2) <<< 14) + 36'(p_cdx_reg) - 36'(p_sdy_reg)
                 + $signed({20'b0, cfg.dw[16:1]});
    assign num_y = (36'(job_reg.cy2) <<< 14) + 36'(p_sdx_reg) + 36'(p_cdy_reg)
                 + $signed({20'b0, cfg.dh[16:1]});
    assign num_u = $signed({9'b0, tsel_u, 10'b0} + {24'b0, cfg.tw[12:1]});
    assign num_v = $signed({9'b0, tsel_v, 10'b0} + {24'b0, cfg.th[12:1]});

    assign div_start = (state_reg == B_START);

    svs_divider u_div_x (.clk(clk), .rst_n(rst_n), .start(div_start),
                         .num(num_x), .den(cfg.dw), .res(rx));
    svs_divider u_div_y (.clk(clk), .rst_n(rst_n), .start(div_start),
                         .num(num_y), .den(cfg.dh), .res(ry));
    svs_divider u_div_u (.clk(clk), .rst_n(rst_n), .start(div_start),
                         .num(num_u), .den({4'b0, cfg.tw}), .res(ru));
    svs_divider u_div_v (.clk(clk), .rst_n(rst_n), .start(div_start),
                         .num(num_v), .den({4'b0, cfg.th}), .res(rv));

    assign all_done = rx.done & ry.done & ru.done & rv.done;

    always_comb
    begin
        vert.corner_index = corner_reg;
        if (rx.ovf)
            vert.ndc_x = rx.neg ? 16'sh8000 : 16'sh7fff;
        else
            vert.ndc_x = sat_s16(19'(rx.quo) - $signed({3'b0, ONE_Q14}));
        if (ry.ovf)
            vert.ndc_y = ry.neg ? 16'sh7fff : 16'sh8000;
        else
            vert.ndc_y = sat_s16($signed({3'b0, ONE_Q14}) - 19'(ry.quo));
        vert.tex_u       = ru.ovf ? 16'hffff : ru.quo[15:0];
        vert.tex_v       = rv.ovf ? 16'hffff : rv.quo[15:0];
        vert.vertex_rgba = job_reg.rgba;
        vert.last_corner = (corner_reg == 2'd3);
    end

    assign out_load       = (state_reg == B_OUT) & (!out_valid_reg | !vtx_stall);
    assign out_valid_next = out_load | (out_valid_reg & vtx_stall);
    assign q_pop          = (state_reg == B_IDLE) & q_valid;

    always_comb
    begin
        state_next  = state_reg;
        corner_next = corner_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next  = B_MUL;
                    corner_next = 2'd0;
                end
            end
            B_MUL:   state_next = B_START;
            B_START: state_next = B_DIV;
            B_DIV:
            begin
                if (all_done)
                    state_next = B_OUT;
            end
            B_OUT:
            begin
                if (out_load)
                begin
                    if (corner_reg == 2'd3)
                        state_next = B_IDLE;
                    else
                    begin
                        state_next  = B_MUL;
                        corner_next = corner_reg + 2'd1;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            corner_reg    <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            corner_reg    <= corner_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            job_reg <= q_head;
        if (state_reg == B_MUL)
        begin
            p_cdx_reg <= job_reg.cs * dx;
            p_sdy_reg <= job_reg.sn * dy;
            p_sdx_reg <= job_reg.sn * dx;
            p_cdy_reg <= job_reg.cs * dy;
        end
        if (out_load)
            out_reg <= vert;
    end

    assign vtx_valid = out_valid_reg;
    assign vtx       = out_reg;

    `SVS_ASSERT_IMP(a_out_no_overwrite, clk, rst_n, out_load, !out_valid_reg || !vtx_stall)
    `SVS_ASSERT_NXT(a_mul_then_start, clk, rst_n, state_reg == B_MUL, state_reg == B_START)
    `SVS_ASSERT_IMP(a_pop_in_idle, clk, rst_n, q_pop, state_reg == B_IDLE && q_valid)

endmodule

FILE: hw/rtl/sprite_quad_vertex_setup.sv
// Rotated sprite quad vertex setup: one draw request in, four vertices out.
// Request channel: req_valid / req_stall / req; a request is taken when valid is high
// and stall is low. Vertex channel: vtx_valid / vtx_stall / vtx, same rule, vertices in
// order top-left, top-right, bottom-left, bottom-right, last_corner set on the fourth.
// Configuration: cfg_write / cfg_index / cfg_data; user must write only while idle, not enforced.
// After reset the sine table is built in place, with req_stall high until it is done.
// Registers reset to 1280x720 viewport, 256x256 texture, visible.
// Each vertex goes through the rotation products, then the 16-step dividers for NDC
// and texture coordinates, then the output register. A two-entry queue lets new
// requests be taken while vertices are still being produced. With visible = 0
// requests are taken and dropped.
// When the receiver stalls, the output register holds its vertex and the back end
// waits; the queue then fills and req_stall rises.
// Depends on svs_pkg, svs_sine_rom, svs_front, svs_divider and svs_back.
module sprite_quad_vertex_setup (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  svs_pkg::svs_in_t  req,
    output logic              vtx_valid,
    input  logic              vtx_stall,
    output svs_pkg::svs_out_t vtx,
    input  logic              cfg_write,
    input  logic [2:0]        cfg_index,
    input  logic [12:0]       cfg_data
);
    import svs_pkg::*;

    logic [12:0] vw_reg, vh_reg, tw_reg, th_reg;
    logic        visible_reg;
    logic [12:0] vw_nz, vh_nz, tw_nz, th_nz;
    svs_cfg_t    cfg;

    logic                   rom_rd_en, rom_busy;
    logic [SINE_ADDR_W-1:0] rom_addr_a, rom_addr_b;
    logic signed [15:0]     rom_data_a, rom_data_b;
    logic                   q_valid, q_pop;
    svs_job_t               q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vw_reg      <= RST_VIEWPORT_W;
            vh_reg      <= RST_VIEWPORT_H;
            tw_reg      <= RST_TEXTURE_W;
            th_reg      <= RST_TEXTURE_H;
            visible_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_VIEWPORT_W: vw_reg      <= cfg_data;
                REG_VIEWPORT_H: vh_reg      <= cfg_data;
                REG_TEXTURE_W:  tw_reg      <= cfg_data;
                REG_TEXTURE_H:  th_reg      <= cfg_data;
                REG_VISIBLE:    visible_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // a zero size behaves as one
    assign vw_nz  = (vw_reg == '0) ? 13'd1 : vw_reg;
    assign vh_nz  = (vh_reg == '0) ? 13'd1 : vh_reg;
    assign tw_nz  = (tw_reg == '0) ? 13'd1 : tw_reg;
    assign th_nz  = (th_reg == '0) ? 13'd1 : th_reg;
    assign cfg.dw = {vw_nz, 4'b0};
    assign cfg.dh = {vh_nz, 4'b0};
    assign cfg.tw = tw_nz;
    assign cfg.th = th_nz;

    svs_sine_rom u_rom (
        .clk(clk), .rst_n(rst_n), .rd_en(rom_rd_en),
        .addr_a(rom_addr_a), .addr_b(rom_addr_b),
        .data_a(rom_data_a), .data_b(rom_data_b), .busy(rom_busy)
    );

    svs_front u_front (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .visible(visible_reg),
        .rom_rd_en(rom_rd_en), .rom_addr_a(rom_addr_a), .rom_addr_b(rom_addr_b),
        .rom_data_a(rom_data_a), .rom_data_b(rom_data_b), .rom_busy(rom_busy),
        .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop)
    );

    svs_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg),
        .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
        .vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx(vtx)
    );

endmodule

FILE: bench/tb.sv
// Testbench for sprite_quad_vertex_setup: random and directed sprite requests,
// a self-checking scoreboard that predicts the four vertices of each sprite.
// Depends on svs_pkg and the block's RTL only.
module tb;
    import svs_pkg::*;

    class vertex_scoreboard;
        int          sine_tab[SINE_TABLE_ENTRIES];
        int unsigned vp_w, vp_h, tx_w, tx_h;
        bit          show;
        svs_out_t    pending_vertices[$];
        int          errors;

        function new();
            int unsigned p, q, r, z, z2, t;
            for (int i = 0; i < SINE_TABLE_ENTRIES; i++)
            begin
                p = (i * 65536) / SINE_TABLE_ENTRIES;
                q = (p >> 14) & 3;
                r = p & 16'h3fff;
                z = (q & 1) ? 16384 - r : r;
                z2 = (z * z) >> 14;
                t = (1160 * z2) >> 14;
                t = ((10512 - t) * z2) >> 14;
                t = ((25736 - t) * z) >> 14;
                if (t > 16384)
                    t = 16384;
                sine_tab[i] = (q >= 2) ? -int'(t) : int'(t);
            end
            vp_w = 1280;
            vp_h = 720;
            tx_w = 256;
            tx_h = 256;
            show = 1;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [12:0] val);
            case (idx)
                REG_VIEWPORT_W: vp_w = val;
                REG_VIEWPORT_H: vp_h = val;
                REG_TEXTURE_W:  tx_w = val;
                REG_TEXTURE_H:  tx_h = val;
                REG_VISIBLE:    show = val[0];
                default: ;
            endcase
        endfunction

        function longint floor_round(longint n, longint d);
            longint m;
            m = n + d / 2;
            if (m >= 0)
                return m / d;
            return -((-m + d - 1) / d);
        endfunction

        function logic [15:0] clamp_s16(longint v);
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            return v[15:0];
        endfunction

        function logic [15:0] texel_norm(longint t, longint dim);
            longint q;
            q = (t * 1024 + dim / 2) / dim;
            return (q > 65535) ? 16'hffff : q[15:0];
        endfunction

        function void note_request(svs_in_t r);
            longint sn, cs, cx, cy, dw, dh, dx, dy, x, y, tw, th;
            svs_out_t v;
            if (!show)
                return;
            dw = 16 * ((vp_w == 0) ? 1 : vp_w);
            dh = 16 * ((vp_h == 0) ? 1 : vp_h);
            tw = (tx_w == 0) ? 1 : tx_w;
            th = (tx_h == 0) ? 1 : tx_h;
            sn = sine_tab[r.angle_bam >> 6];
            cs = sine_tab[16'(r.angle_bam + 16'd16384) >> 6];
            cx = (2 * longint'(r.pos_x) + r.size_x) * 16384;
            cy = (2 * longint'(r.pos_y) + r.size_y) * 16384;
            for (int k = 0; k < 4; k++)
            begin
                dx = (k & 1) ? longint'(r.size_x) : -longint'(r.size_x);
                dy = (k & 2) ? longint'(r.size_y) : -longint'(r.size_y);
                x = cx + cs * dx - sn * dy;
                y = cy + sn * dx + cs * dy;
                v.corner_index = 2'(k);
                v.ndc_x = clamp_s16(floor_round(x, dw) - 16384);
                v.ndc_y = clamp_s16(16384 - floor_round(y, dh));
                v.tex_u = texel_norm((k & 1) ? longint'(r.src_x) + r.src_w : r.src_x, tw);
                v.tex_v = texel_norm((k & 2) ? longint'(r.src_y) + r.src_h : r.src_y, th);
                v.vertex_rgba = r.tint_rgba;
                v.last_corner = (k == 3);
                pending_vertices.push_back(v);
            end
        endfunction

        function void check_vertex(svs_out_t got);
            svs_out_t want;
            if (pending_vertices.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected vertex %h", got);
                return;
            end
            want = pending_vertices.pop_front();
            if (got.corner_index !== want.corner_index || got.ndc_x !== want.ndc_x ||
                got.ndc_y !== want.ndc_y || got.tex_u !== want.tex_u ||
                got.tex_v !== want.tex_v || got.vertex_rgba !== want.vertex_rgba ||
                got.last_corner !== want.last_corner)
            begin
                errors++;
                if (errors <= 10)
                    $display("vertex mismatch: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    svs_in_t     req;
    logic        vtx_valid;
    logic        vtx_stall;
    svs_out_t    vtx;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [12:0] cfg_data;

    vertex_scoreboard sb = new();

    sprite_quad_vertex_setup DUT (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx(vtx),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    always @(posedge clk)
        if (rst_n && vtx_valid && !vtx_stall)
            sb.check_vertex(vtx);

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            repeat (pick_gap()) @(posedge clk);
            vtx_stall <= 1'b1;
            repeat (pick_gap() + 1) @(posedge clk);
            vtx_stall <= 1'b0;
            @(posedge clk);
        end
    end

    // valid stays high across back-to-back requests
    task automatic send_request(svs_in_t item);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(item);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [12:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        cfg_write <= 1'b0;
        while (sb.pending_vertices.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic set_dims(int vw, int vh, int tw, int th);
        write_reg(REG_VIEWPORT_W, 13'(vw));
        write_reg(REG_VIEWPORT_H, 13'(vh));
        write_reg(REG_TEXTURE_W, 13'(tw));
        write_reg(REG_TEXTURE_H, 13'(th));
        cfg_write <= 1'b0;
    endtask

    function automatic svs_in_t rand_request();
        svs_in_t r;
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        r = raw[175:0];
        // keep many sprites on screen with modest sizes
        if ($urandom_range(2) != 0)
        begin
            r.pos_x = 16'($urandom_range(20479));
            r.pos_y = 16'($urandom_range(12000));
            r.size_x = 16'($urandom_range(4096) - 1024);
            r.size_y = 16'($urandom_range(4096) - 1024);
            r.src_x = 16'($urandom_range(4095));
            r.src_y = 16'($urandom_range(4095));
            r.src_w = 16'($urandom_range(1023));
            r.src_h = 16'($urandom_range(1023));
        end
        return r;
    endfunction

    task automatic random_batch(int n);
        repeat (n) send_request(rand_request());
    endtask

    initial
    begin
        svs_in_t d;
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        vtx_stall = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);

        // directed: angle quadrants, field extremes, mirrored and empty rects
        for (int i = 0; i < 20; i++)
        begin
            d = '0;
            d.pos_x = 16'sd3200;
            d.pos_y = 16'sd1600;
            d.size_x = 16'sd640;
            d.size_y = 16'sd320;
            d.src_x = 16'd160;
            d.src_y = 16'd320;
            d.src_w = 16'd512;
            d.src_h = 16'd256;
            d.tint_rgba = 32'h11223344 + i;
            case (i)
                0: d.angle_bam = 16'd0;
                1: d.angle_bam = 16'd16384;
                2: d.angle_bam = 16'd32768;
                3: d.angle_bam = 16'd49152;
                4: d.angle_bam = 16'hffff;
                5: d.angle_bam = 16'd8192;
                6: begin d.size_x = -16'sd640; d.size_y = -16'sd320; end
                7: begin d.size_x = 16'sd0; d.size_y = 16'sd0; end
                8: begin d.pos_x = 16'sh7fff; d.pos_y = 16'sh7fff; end
                9: begin d.pos_x = -16'sd32768; d.pos_y = -16'sd32768; end
                10: begin d.size_x = 16'sh7fff; d.size_y = 16'sh7fff; end
                11: begin d.size_x = -16'sd32768; d.size_y = -16'sd32768; end
                12: begin d.src_x = 16'hffff; d.src_w = 16'hffff;
                          d.src_y = 16'hffff; d.src_h = 16'hffff; end
                13: d.tint_rgba = 32'hffffffff;
                14: d.tint_rgba = 32'h0;
                15: begin d.angle_bam = 16'd12345; d.pos_x = -16'sd100; end
                default: d = rand_request();
            endcase
            send_request(d);
        end
        settle();

        set_dims(1, 1, 1, 1);
        random_batch(20);
        settle();

        set_dims(4096, 4096, 4096, 4096);
        random_batch(20);
        settle();

        // zero sizes act as one, oversized registers used as written
        set_dims(0, 8191, 8191, 0);
        write_reg(3'd5, 13'd7);
        write_reg(3'd6, 13'h1fff);
        write_reg(3'd7, 13'd0);
        cfg_write <= 1'b0;
        random_batch(20);
        settle();

        write_reg(REG_VISIBLE, 13'd0);
        cfg_write <= 1'b0;
        random_batch(10);
        settle();
        write_reg(REG_VISIBLE, 13'd1);
        cfg_write <= 1'b0;

        for (int ph = 0; ph < 4; ph++)
        begin
            set_dims($urandom_range(4096, 1), $urandom_range(4096, 1),
                     $urandom_range(4096, 1), $urandom_range(4096, 1));
            random_batch(13);
            settle();
        end
        set_dims(1280, 720, 256, 256);
        random_batch(20);
        settle();

        if (sb.errors == 0 && sb.pending_vertices.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("tb: failure");
        $finish;
    end
endmodule
